### hdl/string_key_hash_map_macros.svh
// -----------------------------------------------------------------------------
// string_key_hash_map_macros
// Assertion macros shared by the hash map RTL.
// -----------------------------------------------------------------------------
`ifndef STRING_KEY_HASH_MAP_MACROS_SVH
`define STRING_KEY_HASH_MAP_MACROS_SVH

// Asserts that prop holds at every rising edge outside reset.
`define SKHM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Asserts an implication checked at every rising edge, reset included.
`define SKHM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/skhm_pkg.sv
// -----------------------------------------------------------------------------
// skhm_pkg
// Types, constants and the hash step shared by the hash map modules.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package skhm_pkg;
  localparam int CAPACITY_DEFAULT = 256;
  localparam int MAX_KEY_BYTES_DEFAULT = 16;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MUL = 64'h00000100000001b3;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef struct packed {
    logic        kind;
    logic        byte_valid;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [63:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_out;
    logic [7:0]  slot;
    logic [8:0]  entry_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic hash_step;
    logic start_probe;
    logic mem_read;
    logic advance;
    logic finish_match;
    logic finish_insert;
    logic finish_miss;
    logic finish_full;
    logic finish_long;
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic overflow;
    logic occupied;
    logic key_hit;
    logic wrapped_all;
  } stat_t;

  // FNV-1a multiply: the prime is 2^40 + 435, so the product modulo 2^64 is a
  // small constant multiply plus a shift.
  function automatic logic [63:0] fnv_step(input logic [63:0] h);
    logic [63:0] lo;
    lo = h * 64'd435;
    return lo + {h[23:0], 40'd0};
  endfunction
endpackage
`default_nettype wire

### hdl/skhm_ctrl.sv
// -----------------------------------------------------------------------------
// skhm_ctrl
// Sequencer for byte collection, linear probing and result delivery.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module skhm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire skhm_pkg::stat_t stat,
  output skhm_pkg::cmd_t     cmd
);
  import skhm_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_HASH;
      end
      S_HASH: begin
        if (!stat.is_last) state_next = S_IDLE;
        else if (stat.overflow) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (!stat.occupied || stat.key_hit || stat.wrapped_all) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take_byte = in_valid;
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.start_probe = stat.is_last && !stat.overflow;
        cmd.finish_long = stat.is_last && stat.overflow;
      end
      S_READ: cmd.mem_read = 1'b1;
      S_CHECK: begin
        if (stat.occupied && stat.key_hit) cmd.finish_match = 1'b1;
        else if (!stat.occupied) cmd.finish_insert = 1'b1;
        else if (stat.wrapped_all) cmd.finish_full = 1'b1;
        else cmd.advance = 1'b1;
      end
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### hdl/skhm_dp.sv
// -----------------------------------------------------------------------------
// skhm_dp
// Key collection, FNV-1a hash, slot memories and probe datapath.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module skhm_dp #(
  parameter int CAPACITY = skhm_pkg::CAPACITY_DEFAULT,
  parameter int MAX_KEY_BYTES = skhm_pkg::MAX_KEY_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire skhm_pkg::in_beat_t in_beat,
  input  wire skhm_pkg::cmd_t     cmd,
  output skhm_pkg::stat_t         stat,
  output skhm_pkg::out_beat_t     out_beat
);
  import skhm_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KW = 8 * MAX_KEY_BYTES;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KI = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [63:0]     hash;
  logic [63:0]     hash_part;
  logic [KW-1:0]   key_buf;
  logic [LW-1:0]   key_len;
  logic            overflow;
  in_beat_t        beat;
  logic [IW-1:0]   idx;
  logic [CW-1:0]   steps;
  logic [CW-1:0]   count;
  logic [KW-1:0]   rd_key;
  logic [LW-1:0]   rd_len;
  logic [63:0]     rd_val;
  logic            rd_occ;
  logic [KW-1:0]   mem_key [CAPACITY];
  logic [LW-1:0]   mem_len [CAPACITY];
  logic [63:0]     mem_val [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [IW-1:0]   idx_inc;
  logic            wr_en;

  assign idx_inc = (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  assign wr_en = cmd.finish_insert && beat.kind;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) beat <= in_beat;
    if (cmd.take_byte && in_beat.byte_valid) hash_part <= fnv_step(hash ^ {56'd0, in_beat.key_byte});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FNV_BASIS;
      key_buf <= '0;
      key_len <= '0;
      overflow <= 1'b0;
      count <= '0;
      occ <= '0;
    end else begin
      if (wr_en) begin
        occ[idx] <= 1'b1;
        count <= count + 1'b1;
      end
      if (cmd.finish_match || cmd.finish_insert || cmd.finish_full || cmd.finish_long) begin
        hash <= FNV_BASIS;
        key_buf <= '0;
        key_len <= '0;
        overflow <= 1'b0;
      end else if (cmd.hash_step && beat.byte_valid) begin
        hash <= hash_part;
        if (key_len < LW'(MAX_KEY_BYTES)) begin
          key_buf[8*key_len[KI-1:0] +: 8] <= beat.key_byte;
          key_len <= key_len + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_probe) begin
      idx <= beat.byte_valid ? IW'(hash_part) : IW'(hash);
      steps <= '0;
    end else if (cmd.advance) begin
      idx <= idx_inc;
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_key <= mem_key[idx];
      rd_len <= mem_len[idx];
      rd_val <= mem_val[idx];
      rd_occ <= occ[idx];
    end
    if (wr_en) begin
      mem_key[idx] <= key_buf;
      mem_len[idx] <= key_len;
    end
    if (wr_en || (cmd.finish_match && beat.kind)) mem_val[idx] <= beat.value_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_long) begin
      out_beat <= '{ST_TOO_LONG, 64'd0, 8'd0, 9'(count)};
    end
    if (cmd.finish_full) begin
      out_beat <= '{ST_FULL, 64'd0, 8'd0, 9'(count)};
    end
    if (cmd.finish_match) begin
      out_beat <= '{beat.kind ? ST_UPDATED : ST_FOUND, beat.kind ? 64'd0 : rd_val,
                    8'(idx), 9'(count)};
    end
    if (cmd.finish_insert) begin
      out_beat <= beat.kind ? '{ST_INSERTED, 64'd0, 8'(idx), 9'(count + 1'b1)}
                            : '{ST_NOT_FOUND, 64'd0, 8'd0, 9'(count)};
    end
  end

  assign stat.is_last = beat.key_last;
  assign stat.overflow = overflow || (beat.byte_valid && key_len == LW'(MAX_KEY_BYTES));
  assign stat.occupied = rd_occ;
  assign stat.key_hit = (rd_len == key_len) && (rd_key == key_buf);
  assign stat.wrapped_all = (steps == CW'(CAPACITY - 1));
endmodule
`default_nettype wire

### hdl/string_key_hash_map.sv
// -----------------------------------------------------------------------------
// string_key_hash_map
// Open-addressing map with byte-string keys and 64-bit values.
// -----------------------------------------------------------------------------
// A key streams in one byte per input beat, each hashed before the next is taken.
// The last beat of a key starts a linear probe from the FNV-1a hash of the key;
// each probed slot takes one synchronous read of the slot memory and one
// compare, and the result beat is offered once the probe ends.
// Keys are compared whole against the stored key; occupancy after reset is
// held in per-slot valid flops and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "string_key_hash_map_macros.svh"
module string_key_hash_map #(
  parameter int CAPACITY = skhm_pkg::CAPACITY_DEFAULT,
  parameter int MAX_KEY_BYTES = skhm_pkg::MAX_KEY_BYTES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skhm_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skhm_pkg::out_beat_t      out_data
);
  import skhm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  skhm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  skhm_dp #(.CAPACITY(CAPACITY), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
    .clk(clk), .rst(rst), .in_beat(in_data), .cmd(cmd), .stat(stat),
    .out_beat(out_data)
  );

  `SKHM_ASSERT(a_no_overlap, !(in_ready && out_valid), "input and output both open")
  `SKHM_ASSERT(a_count_bound, out_data.entry_count <= 9'(CAPACITY) || !out_valid, "count above capacity")
  `SKHM_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result after reset")
endmodule
`default_nettype wire
